### hdl/pwac_pkg.sv
package pwac_pkg;

    localparam int GAIN_WIDTH    = 16;
    localparam int LIMIT_WIDTH   = 15;
    localparam int DRIVE_WIDTH   = 16;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 16;

    localparam int WRAP_HALF = 180;
    localparam int WRAP_FULL = 360;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_DRIVE_LIMIT    = 3'd3,
        CFG_INTEGRAL_LIMIT = 3'd4,
        CFG_ANGLE_MODE     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

### hdl/pwac_front.sv
module pwac_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            angle_mode,
    input  logic                            push,
    input  logic signed [SAMPLE_WIDTH-1:0]  feedback,
    input  logic signed [SAMPLE_WIDTH-1:0]  target,
    output logic signed [SAMPLE_WIDTH:0]    err,
    output logic signed [SAMPLE_WIDTH+1:0]  derr
);

    localparam int EW = SAMPLE_WIDTH + 1;
    localparam int XW = SAMPLE_WIDTH + 2;
    localparam logic signed [XW-1:0] HALF = XW'(pwac_pkg::WRAP_HALF);
    localparam logic signed [XW-1:0] FULL = XW'(pwac_pkg::WRAP_FULL);

    logic signed [EW-1:0] last_error_reg;
    logic signed [EW-1:0] last_error_next;
    logic signed [XW-1:0] err_raw;
    logic signed [XW-1:0] err_wrap;

    always_comb begin
        err_raw = XW'(target) - XW'(feedback);
        err_wrap = err_raw;
        if (angle_mode) begin
            if (err_raw > HALF) begin
                err_wrap = err_raw - FULL;
            end else if (err_raw < -HALF) begin
                err_wrap = err_raw + FULL;
            end
        end
        err = err_wrap[EW-1:0];
        derr = XW'(err) - XW'(last_error_reg);
        last_error_next = push ? err : last_error_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg <= '0;
        end else begin
            last_error_reg <= last_error_next;
        end
    end

endmodule

### hdl/pwac_fifo.sv
module pwac_fifo #(
    parameter int DATA_WIDTH = 35
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] push_data,
    input  logic                  pop,
    output logic [DATA_WIDTH-1:0] pop_data,
    output pwac_pkg::fifo_status_t status
);

    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    logic [DATA_WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [PW:0]           count_reg, count_next;

    always_comb begin
        status.full  = (count_reg == (PW+1)'(DEPTH));
        status.empty = (count_reg == '0);
        pop_data     = entry_reg[rd_ptr_reg];
        wr_ptr_next  = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next   = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/pwac_back.sv
module pwac_back #(
    parameter int GAIN_FRAC_BITS = 8,
    parameter int SAMPLE_WIDTH   = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic signed [pwac_pkg::GAIN_WIDTH-1:0]     gain_p,
    input  logic signed [pwac_pkg::GAIN_WIDTH-1:0]     gain_i,
    input  logic signed [pwac_pkg::GAIN_WIDTH-1:0]     gain_d,
    input  logic [pwac_pkg::LIMIT_WIDTH-1:0]           drive_limit,
    input  logic [pwac_pkg::LIMIT_WIDTH-1:0]           integral_limit,
    input  pwac_pkg::fifo_status_t                     q_status,
    input  logic signed [SAMPLE_WIDTH:0]               q_err,
    input  logic signed [SAMPLE_WIDTH+1:0]             q_derr,
    output logic                                       q_pop,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic signed [pwac_pkg::DRIVE_WIDTH-1:0]    m_drive
);

    localparam int GW   = pwac_pkg::GAIN_WIDTH;
    localparam int LW   = pwac_pkg::LIMIT_WIDTH;
    localparam int F    = GAIN_FRAC_BITS;
    localparam int EW   = SAMPLE_WIDTH + 1;
    localparam int DW   = SAMPLE_WIDTH + 2;
    localparam int PPW  = GW + EW;
    localparam int PDW  = GW + DW;
    localparam int AW   = LW + F + 1;
    localparam int IW   = ((AW > PPW) ? AW : PPW) + 1;
    localparam int PSW  = PDW + 1;
    localparam int SUMW = ((AW > PSW) ? AW : PSW) + 1;
    localparam int TW   = AW + 1;
    localparam logic signed [TW-1:0] RND = TW'((1 << F) - 1);

    logic                    adv;
    logic                    v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic signed [PPW-1:0]   prod_p_reg, prod_i_reg;
    logic signed [PDW-1:0]   prod_d_reg;
    logic signed [PSW-1:0]   pd_reg;
    logic signed [AW-1:0]    acc_reg, acc_next;
    logic signed [AW-1:0]    clamp_reg, clamp_next;
    logic signed [pwac_pkg::DRIVE_WIDTH-1:0] m_drive_reg, m_drive_next;
    logic signed [PPW-1:0]   prod_p_next, prod_i_next;
    logic signed [PDW-1:0]   prod_d_next;
    logic signed [AW-1:0]    ilim, dlim;
    logic signed [IW-1:0]    isum;
    logic signed [SUMW-1:0]  dsum;
    logic signed [TW-1:0]    tsum;
    logic signed [TW-1:0]    tshift;

    always_comb begin
        adv   = !m_valid_reg || m_ready;
        q_pop = adv && !q_status.empty;

        prod_p_next = gain_p * q_err;
        prod_i_next = gain_i * q_err;
        prod_d_next = gain_d * q_derr;

        ilim = AW'(integral_limit) <<< F;
        dlim = AW'(drive_limit) <<< F;

        isum = IW'(acc_reg) + IW'(prod_i_reg);
        priority if (isum > IW'(ilim)) begin
            acc_next = ilim;
        end else if (isum < -IW'(ilim)) begin
            acc_next = -ilim;
        end else begin
            acc_next = isum[AW-1:0];
        end

        dsum = SUMW'(pd_reg) + SUMW'(acc_reg);
        priority if (dsum > SUMW'(dlim)) begin
            clamp_next = dlim;
        end else if (dsum < -SUMW'(dlim)) begin
            clamp_next = -dlim;
        end else begin
            clamp_next = dsum[AW-1:0];
        end

        tsum = clamp_reg[AW-1] ? TW'(clamp_reg) + RND : TW'(clamp_reg);
        tshift = tsum >>> F;
        m_drive_next = tshift[pwac_pkg::DRIVE_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end else if (adv) begin
            v1_reg      <= q_pop;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
            if (v1_reg) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_p_reg  <= prod_p_next;
            prod_i_reg  <= prod_i_next;
            prod_d_reg  <= prod_d_next;
            pd_reg      <= PSW'(prod_p_reg) + PSW'(prod_d_reg);
            clamp_reg   <= clamp_next;
            m_drive_reg <= m_drive_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_drive = m_drive_reg;

endmodule

### hdl/pid_controller_with_angle_wrap_unit.sv
// path: queue, product, sum, clamp and output registers; throughput: one transaction
// per cycle unless stalled, set by three parallel multipliers and a single-register
// integrator loop; a 4-entry queue absorbs output stalls
// reset: synchronous active-low aresetn clears error history, integral,
// queue and valids; gains reset to 0, limits to 32767, angle mode off
module pid_controller_with_angle_wrap_unit #(
    parameter int GAIN_FRAC_BITS = 8,
    parameter int SAMPLE_WIDTH   = 16
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_valid,
    output logic                                         s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]               s_feedback,
    input  logic signed [SAMPLE_WIDTH-1:0]               s_target,
    output logic                                         m_valid,
    input  logic                                         m_ready,
    output logic signed [pwac_pkg::DRIVE_WIDTH-1:0]      m_drive,
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [pwac_pkg::CFG_IDX_WIDTH-1:0]           cfg_index,
    input  logic [pwac_pkg::CFG_DATA_WIDTH-1:0]          cfg_data
);

    localparam int EW = SAMPLE_WIDTH + 1;
    localparam int DW = SAMPLE_WIDTH + 2;
    localparam int GW = pwac_pkg::GAIN_WIDTH;
    localparam int LW = pwac_pkg::LIMIT_WIDTH;

    logic signed [GW-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [LW-1:0]        drive_limit_reg, integral_limit_reg;
    logic                 angle_mode_reg;

    logic                    push;
    logic                    pop;
    logic signed [EW-1:0]    err;
    logic signed [DW-1:0]    derr;
    logic [EW+DW-1:0]        q_out;
    pwac_pkg::fifo_status_t  q_status;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_status.full;
    assign push      = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            drive_limit_reg    <= '1;
            integral_limit_reg <= '1;
            angle_mode_reg     <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (pwac_pkg::cfg_idx_t'(cfg_index))
                pwac_pkg::CFG_GAIN_P:         gain_p_reg         <= cfg_data[GW-1:0];
                pwac_pkg::CFG_GAIN_I:         gain_i_reg         <= cfg_data[GW-1:0];
                pwac_pkg::CFG_GAIN_D:         gain_d_reg         <= cfg_data[GW-1:0];
                pwac_pkg::CFG_DRIVE_LIMIT:    drive_limit_reg    <= cfg_data[LW-1:0];
                pwac_pkg::CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[LW-1:0];
                pwac_pkg::CFG_ANGLE_MODE:     angle_mode_reg     <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    pwac_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .angle_mode (angle_mode_reg),
        .push       (push),
        .feedback   (s_feedback),
        .target     (s_target),
        .err        (err),
        .derr       (derr)
    );

    pwac_fifo #(
        .DATA_WIDTH(EW + DW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({err, derr}),
        .pop       (pop),
        .pop_data  (q_out),
        .status    (q_status)
    );

    pwac_back #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .gain_p         (gain_p_reg),
        .gain_i         (gain_i_reg),
        .gain_d         (gain_d_reg),
        .drive_limit    (drive_limit_reg),
        .integral_limit (integral_limit_reg),
        .q_status       (q_status),
        .q_err          (q_out[EW+DW-1:DW]),
        .q_derr         (q_out[DW-1:0]),
        .q_pop          (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive        (m_drive)
    );

endmodule

### tb/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 8;
    localparam int FRAC_BITS  = 8;
    localparam int SAMPLE_W   = 16;
    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 136;
    localparam int TAIL_CYCLES = 20;

    localparam logic [pwac_pkg::CFG_IDX_WIDTH-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [pwac_pkg::CFG_IDX_WIDTH-1:0] CFG_IDX_SPARE_HI = 3'd7;

    class pid_scoreboard;
        logic signed [pwac_pkg::GAIN_WIDTH-1:0]  kp, ki, kd;
        logic        [pwac_pkg::LIMIT_WIDTH-1:0] drive_lim, integ_lim;
        logic                                    wrap_on;
        longint                                  prev_err, integ;
        logic signed [pwac_pkg::DRIVE_WIDTH-1:0] expected_drive[$];
        int                                      mismatches;

        function new();
            kp = '0;
            ki = '0;
            kd = '0;
            drive_lim = '1;
            integ_lim = '1;
            wrap_on = 1'b0;
            prev_err = 0;
            integ = 0;
            mismatches = 0;
        endfunction

        function longint clamp(longint v, longint lim);
            if (v > lim) begin
                return lim;
            end
            if (v < -lim) begin
                return -lim;
            end
            return v;
        endfunction

        function void apply_reg(logic [pwac_pkg::CFG_IDX_WIDTH-1:0] idx,
                                logic [pwac_pkg::CFG_DATA_WIDTH-1:0] data);
            case (idx)
                pwac_pkg::CFG_GAIN_P:         kp = data;
                pwac_pkg::CFG_GAIN_I:         ki = data;
                pwac_pkg::CFG_GAIN_D:         kd = data;
                pwac_pkg::CFG_DRIVE_LIMIT:    drive_lim = data[pwac_pkg::LIMIT_WIDTH-1:0];
                pwac_pkg::CFG_INTEGRAL_LIMIT: integ_lim = data[pwac_pkg::LIMIT_WIDTH-1:0];
                pwac_pkg::CFG_ANGLE_MODE:     wrap_on = data[0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] fb, logic signed [SAMPLE_W-1:0] tg);
            longint err, ilim, dlim, total;
            logic signed [pwac_pkg::DRIVE_WIDTH-1:0] drv;
            err = longint'(tg) - longint'(fb);
            if (wrap_on) begin
                if (err > pwac_pkg::WRAP_HALF) begin
                    err -= pwac_pkg::WRAP_FULL;
                end else if (err < -pwac_pkg::WRAP_HALF) begin
                    err += pwac_pkg::WRAP_FULL;
                end
            end
            ilim = longint'(integ_lim) << FRAC_BITS;
            dlim = longint'(drive_lim) << FRAC_BITS;
            integ = clamp(integ + longint'(ki) * err, ilim);
            total = longint'(kp) * err + integ + longint'(kd) * (err - prev_err);
            total = clamp(total, dlim);
            // signed division truncates toward zero
            drv = pwac_pkg::DRIVE_WIDTH'(total / (longint'(1) << FRAC_BITS));
            prev_err = err;
            expected_drive.push_back(drv);
        endfunction

        function void check_drive(logic signed [pwac_pkg::DRIVE_WIDTH-1:0] got);
            logic signed [pwac_pkg::DRIVE_WIDTH-1:0] exp_drv;
            if (expected_drive.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected drive %0d with nothing outstanding", got);
                end
                return;
            end
            exp_drv = expected_drive.pop_front();
            if (got !== exp_drv) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("drive mismatch: expected %0d, got %0d", exp_drv, got);
                end
            end
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction
    endclass

    logic                                    aclk = 1'b0;
    logic                                    aresetn;
    logic                                    s_valid;
    logic                                    s_ready;
    logic signed [SAMPLE_W-1:0]              s_feedback;
    logic signed [SAMPLE_W-1:0]              s_target;
    logic                                    m_valid;
    logic                                    m_ready = 1'b0;
    logic signed [pwac_pkg::DRIVE_WIDTH-1:0] m_drive;
    logic                                    cfg_valid;
    logic                                    cfg_ready;
    logic [pwac_pkg::CFG_IDX_WIDTH-1:0]      cfg_index;
    logic [pwac_pkg::CFG_DATA_WIDTH-1:0]     cfg_data;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    pid_scoreboard sb;

    pid_controller_with_angle_wrap_unit i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_feedback (s_feedback),
        .s_target   (s_target),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.apply_reg(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                sb.note_sample(s_feedback, s_target);
            end
            if (m_valid && m_ready) begin
                sb.check_drive(m_drive);
            end
        end
    end

    task automatic write_reg(logic [pwac_pkg::CFG_IDX_WIDTH-1:0] idx,
                             logic [pwac_pkg::CFG_DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(logic signed [SAMPLE_W-1:0] fb, logic signed [SAMPLE_W-1:0] tg);
        int gap;
        gap = 0;
        while (($urandom_range(99) < send_idle_pct) && (gap < 20)) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_feedback <= fb;
        s_target   <= tg;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop s_valid and advance the clock before polling, so the last transaction is already noted
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [pwac_pkg::CFG_DATA_WIDTH-1:0] rand_gain();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3, 4:    return 16'($signed($urandom_range(1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [pwac_pkg::CFG_DATA_WIDTH-1:0] rand_limit();
        logic [pwac_pkg::LIMIT_WIDTH-1:0] lim;
        case ($urandom_range(4))
            0:       lim = '0;
            1:       lim = '1;
            2:       lim = 15'($urandom_range(1, 2000));
            default: lim = 15'($urandom);
        endcase
        // bit above the register width is don't care
        return {1'($urandom_range(1)), lim};
    endfunction

    task automatic random_sample();
        logic signed [SAMPLE_W-1:0] fb, tg;
        case ($urandom_range(9))
            0, 1, 2: begin
                fb = 16'($urandom);
                tg = 16'($urandom);
            end
            3, 4, 5, 6: begin
                tg = 16'($urandom);
                fb = tg + 16'($signed($urandom_range(800)) - 400);
            end
            7, 8: begin
                tg = 16'($signed($urandom_range(1440)) - 720);
                fb = 16'($signed($urandom_range(1440)) - 720);
            end
            default: begin
                fb = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                tg = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            end
        endcase
        send_sample(fb, tg);
    endtask

    initial begin
        sb = new();
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_feedback = '0;
        s_target   = '0;
        cfg_valid  = 1'b0;
        cfg_index  = pwac_pkg::CFG_GAIN_P;
        cfg_data   = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset gains give zero drive
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh8000);
        drain();

        // angle wrap edges and single fold
        write_reg(pwac_pkg::CFG_GAIN_P, 16'h0100);
        write_reg(pwac_pkg::CFG_GAIN_I, 16'h0080);
        write_reg(pwac_pkg::CFG_GAIN_D, 16'hFFC0);
        write_reg(pwac_pkg::CFG_DRIVE_LIMIT, 16'hFFFF);
        write_reg(pwac_pkg::CFG_INTEGRAL_LIMIT, 16'h7FFF);
        write_reg(pwac_pkg::CFG_ANGLE_MODE, 16'hFFFF);
        send_sample(16'sd0, 16'sd180);
        send_sample(16'sd0, 16'sd181);
        send_sample(16'sd0, -16'sd180);
        send_sample(16'sd0, -16'sd181);
        send_sample(16'sd0, 16'sd540);
        send_sample(16'sd540, 16'sd0);
        send_sample(16'sd10, 16'sd10);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh8000);
        drain();

        // zero limits, writes to unused indexes are dropped
        write_reg(pwac_pkg::CFG_DRIVE_LIMIT, 16'h8000);
        write_reg(pwac_pkg::CFG_INTEGRAL_LIMIT, 16'h0000);
        write_reg(CFG_IDX_SPARE_LO, 16'hFFFF);
        write_reg(CFG_IDX_SPARE_HI, 16'h1234);
        send_sample(16'sd0, 16'sd100);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sd50, -16'sd50);
        drain();

        // extreme gains, plain error
        write_reg(pwac_pkg::CFG_GAIN_P, 16'h7FFF);
        write_reg(pwac_pkg::CFG_GAIN_I, 16'h8000);
        write_reg(pwac_pkg::CFG_GAIN_D, 16'h8000);
        write_reg(pwac_pkg::CFG_DRIVE_LIMIT, 16'h7FFF);
        write_reg(pwac_pkg::CFG_INTEGRAL_LIMIT, 16'hFFFF);
        write_reg(pwac_pkg::CFG_ANGLE_MODE, 16'hFFFE);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sd0, 16'sd1);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            write_reg(pwac_pkg::CFG_GAIN_P, rand_gain());
            write_reg(pwac_pkg::CFG_GAIN_I, rand_gain());
            write_reg(pwac_pkg::CFG_GAIN_D, rand_gain());
            write_reg(pwac_pkg::CFG_DRIVE_LIMIT, rand_limit());
            write_reg(pwac_pkg::CFG_INTEGRAL_LIMIT, rand_limit());
            write_reg(pwac_pkg::CFG_ANGLE_MODE, 16'($urandom));
            if ($urandom_range(3) == 0) begin
                write_reg($urandom_range(1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI,
                          16'($urandom));
            end
            for (int n = 0; n < PHASE_LEN; n++) begin
                random_sample();
                if (n == PHASE_LEN / 2) begin
                    drain();
                end
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/pwac_pkg.sv
hdl/pwac_front.sv
hdl/pwac_fifo.sv
hdl/pwac_back.sv
hdl/pid_controller_with_angle_wrap_unit.sv
tb/testbench.sv
